// File: hw/rtl/sprite_quad_vertex_expander_assert.svh
// assertion macros for the sprite quad vertex expander
// expects clk and arst_n in the scope of use
`ifndef SPRITE_QUAD_VERTEX_EXPANDER_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_EXPANDER_ASSERT_SVH

// same-cycle implication, off while in reset
`define SVQE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svqe check failed");

// next-cycle implication, off while in reset
`define SVQE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svqe check failed");

`endif

// File: hw/rtl/svqe_pkg.sv
// shared types, constants and helper functions of the sprite quad vertex expander
// no dependencies
`default_nettype none
package svqe_pkg;

	localparam int POS_WIDTH    = 24;
	localparam int UV_FRAC_BITS = 16;
	localparam int TC_WIDTH     = UV_FRAC_BITS + 4;
	localparam int UV_SHIFT     = UV_FRAC_BITS - 8 + 1;
	localparam int ROT_WIDTH    = 17;
	localparam int TEX_WIDTH    = 15;
	localparam int DEPTH_WIDTH  = 16;
	localparam int COLOUR_WIDTH = 32;
	localparam int CFG_WIDTH    = 16;
	localparam int P_WIDTH      = POS_WIDTH + 1;
	localparam int CS_WIDTH     = 20;
	localparam int Z_WIDTH      = 25;
	localparam int PROD_WIDTH   = P_WIDTH + CS_WIDTH;
	localparam int RND_WIDTH    = PROD_WIDTH + 1 - 16;
	localparam int DEG_FULL     = 46080;
	localparam int DEG_HALF     = 23040;
	localparam int DEG_QUARTER  = 11520;
	localparam int CORDIC_GAIN  = 39797;
	localparam int IN_BYTES     = 37;
	localparam int OUT_BYTES    = 17;

	typedef logic signed [POS_WIDTH-1:0] pos_t;
	typedef logic signed [P_WIDTH-1:0]   ext_t;
	typedef logic signed [TC_WIDTH-1:0]  uv_t;
	typedef logic signed [CS_WIDTH-1:0]  cs_t;
	typedef logic signed [Z_WIDTH-1:0]   ang_t;

	typedef enum logic [1:0] {
		REG_TEX_WIDTH  = 2'd0,
		REG_TEX_HEIGHT = 2'd1,
		REG_DEPTH_Z    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		cs_t  x;
		cs_t  y;
		ang_t z;
	} rot_vec_t;

	// arctangent of 2^-i in degrees, Q.16
	function automatic ang_t atan_deg(input logic [3:0] i);
		ang_t r;
		case (i)
			4'd0:    r = 25'sd2949120;
			4'd1:    r = 25'sd1740967;
			4'd2:    r = 25'sd919879;
			4'd3:    r = 25'sd466945;
			4'd4:    r = 25'sd234379;
			4'd5:    r = 25'sd117304;
			4'd6:    r = 25'sd58666;
			4'd7:    r = 25'sd29335;
			4'd8:    r = 25'sd14668;
			4'd9:    r = 25'sd7334;
			4'd10:   r = 25'sd3667;
			4'd11:   r = 25'sd1833;
			4'd12:   r = 25'sd917;
			4'd13:   r = 25'sd458;
			4'd14:   r = 25'sd229;
			default: r = 25'sd115;
		endcase
		return r;
	endfunction

	// one micro-rotation
	function automatic rot_vec_t cordic_step(input rot_vec_t v, input logic [3:0] i);
		rot_vec_t r;
		cs_t xs;
		cs_t ys;
		xs = v.x >>> i;
		ys = v.y >>> i;
		if (v.z >= 0) begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - atan_deg(i);
		end else begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + atan_deg(i);
		end
		return r;
	endfunction

	// clamp a wider position sum into the position range
	function automatic pos_t sat_pos(input logic signed [RND_WIDTH:0] v);
		pos_t r;
		if (v > (RND_WIDTH+1)'(2**(POS_WIDTH-1) - 1))
			r = pos_t'(2**(POS_WIDTH-1) - 1);
		else if (v < -(RND_WIDTH+1)'(2**(POS_WIDTH-1)))
			r = pos_t'(-(2**(POS_WIDTH-1)));
		else
			r = v[POS_WIDTH-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/svqe_cordic.sv
// pipelined sine and cosine of a rotation in 1/128 degree units, nine register stages
// depends on svqe_pkg
`default_nettype none
module svqe_cordic (
	input  wire logic                             clk,
	input  wire logic                             en,
	input  wire logic signed [svqe_pkg::ROT_WIDTH-1:0] rot,
	output logic signed [svqe_pkg::CS_WIDTH-1:0]  cos_val,
	output logic signed [svqe_pkg::CS_WIDTH-1:0]  sin_val
);
	import svqe_pkg::*;

	logic signed [17:0] r0, r1, r2, r3, af;
	logic               fneg;
	ang_t               zin;

	rot_vec_t vec_s [0:8];
	logic     neg_s [0:7];
	logic     zero_s[0:7];

	// reduce to [-180,180) then fold into [-90,90]
	always_comb begin
		r0 = 18'(rot);
		r1 = (r0 < 0) ? r0 + 18'sd46080 : r0;
		if (r1 < 0)
			r2 = r1 + 18'sd46080;
		else if (r1 >= 18'sd46080)
			r2 = r1 - 18'sd46080;
		else
			r2 = r1;
		r3 = (r2 >= 18'sd23040) ? r2 - 18'sd46080 : r2;
		fneg = 1'b0;
		af = r3;
		if (r3 > 18'sd11520) begin
			af = r3 - 18'sd23040;
			fneg = 1'b1;
		end else if (r3 < -18'sd11520) begin
			af = r3 + 18'sd23040;
			fneg = 1'b1;
		end
		zin = Z_WIDTH'(af) <<< 9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0].x <= cs_t'(CORDIC_GAIN);
			vec_s[0].y <= '0;
			vec_s[0].z <= zin;
			neg_s[0]   <= fneg;
			zero_s[0]  <= (rot == '0);
		end
	end

	// two micro-rotations per stage
	for (genvar k = 0; k < 8; k++) begin : g_stage
		rot_vec_t v0, v1;
		always_comb begin
			v0 = cordic_step(vec_s[k], 4'(2*k));
			v1 = cordic_step(v0, 4'(2*k+1));
		end
		if (k < 7) begin : g_mid
			always_ff @(posedge clk) begin
				if (en) begin
					vec_s[k+1]  <= v1;
					neg_s[k+1]  <= neg_s[k];
					zero_s[k+1] <= zero_s[k];
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (en) begin
					vec_s[8].z <= v1.z;
					if (zero_s[7]) begin
						vec_s[8].x <= cs_t'(65536);
						vec_s[8].y <= '0;
					end else begin
						vec_s[8].x <= neg_s[7] ? -v1.x : v1.x;
						vec_s[8].y <= neg_s[7] ? -v1.y : v1.y;
					end
				end
			end
		end
	end

	assign cos_val = vec_s[8].x;
	assign sin_val = vec_s[8].y;

endmodule
`default_nettype wire

// File: hw/rtl/svqe_uv_div.sv
// pipelined texture coordinate divider: round(p * 2^(frac-8) / size), saturated
// nine register stages, four quotient bits in each of stages 3 to 7; depends on svqe_pkg
`default_nettype none
module svqe_uv_div (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire logic signed [svqe_pkg::P_WIDTH-1:0] p,
	input  wire logic [svqe_pkg::TEX_WIDTH-1:0]      size,
	output logic signed [svqe_pkg::TC_WIDTH-1:0]     uv
);
	import svqe_pkg::*;

	localparam int NW = P_WIDTH + UV_SHIFT + 2;
	localparam int DW = TEX_WIDTH + 1;

	ext_t            p_s1;
	logic [DW-1:0]   d_s1;
	logic signed [NW-1:0] num;
	logic signed [NW-1:0] nabs;

	logic [DW-1:0]       rem_s [2:7];
	logic [TC_WIDTH-1:0] q_s   [2:7];
	logic [DW-1:0]       d_s   [2:7];
	logic                ovf_s [2:8];
	logic                neg_s [2:8];
	logic [TC_WIDTH:0]   mag_s8;
	uv_t                 uv_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= p;
			d_s1 <= {(size == '0) ? TEX_WIDTH'(1) : size, 1'b0};
		end
	end

	// numerator plus half the divisor, magnitude and overflow test
	always_comb begin
		num  = (NW'(p_s1) <<< UV_SHIFT) + signed'(NW'(d_s1[DW-1:1]));
		nabs = (num < 0) ? -num : num;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[2] <= DW'(nabs[NW-2:TC_WIDTH]);
			q_s[2]   <= nabs[TC_WIDTH-1:0];
			d_s[2]   <= d_s1;
			ovf_s[2] <= DW'(nabs[NW-2:TC_WIDTH]) >= d_s1;
			neg_s[2] <= num < 0;
		end
	end

	for (genvar k = 3; k <= 7; k++) begin : g_iter
		logic [DW-1:0]       rem_n;
		logic [TC_WIDTH-1:0] q_n;
		logic [DW:0]         trial;
		always_comb begin
			rem_n = rem_s[k-1];
			q_n   = q_s[k-1];
			trial = '0;
			for (int b = 0; b < 4; b++) begin
				trial = {rem_n, q_n[TC_WIDTH-1]};
				if (trial >= (DW+1)'(d_s[k-1])) begin
					rem_n = DW'(trial - (DW+1)'(d_s[k-1]));
					q_n   = {q_n[TC_WIDTH-2:0], 1'b1};
				end else begin
					rem_n = trial[DW-1:0];
					q_n   = {q_n[TC_WIDTH-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_n;
				q_s[k]   <= q_n;
				d_s[k]   <= d_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// floor of a negative quotient rounds away from zero
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s8   <= (TC_WIDTH+1)'(q_s[7])
			          + (TC_WIDTH+1)'(neg_s[7] && (rem_s[7] != '0));
			ovf_s[8] <= ovf_s[7];
			neg_s[8] <= neg_s[7];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[8]) begin
				if (ovf_s[8] || mag_s8 > (TC_WIDTH+1)'(2**(TC_WIDTH-1)))
					uv_s9 <= uv_t'(-(2**(TC_WIDTH-1)));
				else
					uv_s9 <= -uv_t'(mag_s8[TC_WIDTH-1:0]);
			end else begin
				if (ovf_s[8] || mag_s8 > (TC_WIDTH+1)'(2**(TC_WIDTH-1) - 1))
					uv_s9 <= uv_t'(2**(TC_WIDTH-1) - 1);
				else
					uv_s9 <= uv_t'(mag_s8[TC_WIDTH-1:0]);
			end
		end
	end

	assign uv = uv_s9;

endmodule
`default_nettype wire

// File: hw/rtl/sprite_quad_vertex_expander.sv
// an accepted request passes stages 1 to 12 in order; stage 12 presents its first vertex on the output
// each request gives six vertices, one vertex per cycle while m_tready is high
// the twelve pipeline stages advance together; a request can enter every cycle
// while the output register is free, and the pipe holds when a quad is still draining
// reset (arst_n low, asynchronous): valid bits, vertex counter and configuration registers clear
// depends on svqe_pkg, svqe_cordic, svqe_uv_div and the assertion macro header
`default_nettype none
module sprite_quad_vertex_expander (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// request: dst_x, dst_y, dst_w, dst_h, src_x, src_y, src_w, src_h,
	// rot_deg, origin_x, origin_y, colour, then zero fill
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [svqe_pkg::IN_BYTES*8-1:0]        s_tdata,
	// vertex: vtx_x, vtx_y, vtx_u, vtx_v, vtx_colour, vtx_depth
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [svqe_pkg::OUT_BYTES*8-1:0]            m_tdata,
	output logic                                        m_tlast,
	// configuration writes
	input  wire logic                                   cfg_we,
	input  wire logic [1:0]                             cfg_addr,
	input  wire logic [svqe_pkg::CFG_WIDTH-1:0]         cfg_wdata
);
	import svqe_pkg::*;

	localparam logic [2:0] LAST_VTX = 3'd5;

	// request fields travelling next to the cordic and dividers
	typedef struct packed {
		pos_t                    dst_x;
		pos_t                    dst_y;
		ext_t                    ax0;
		ext_t                    ax1;
		ext_t                    by0;
		ext_t                    by1;
		logic [COLOUR_WIDTH-1:0] colour;
		logic                    flip;
	} side_t;

	// configuration registers
	logic [TEX_WIDTH-1:0]          tex_width_q;
	logic [TEX_WIDTH-1:0]          tex_height_q;
	logic signed [DEPTH_WIDTH-1:0] depth_z_q;

	// request unpacking
	pos_t dst_x, dst_y, dst_w, dst_h, src_x, src_y, src_w, src_h, origin_x, origin_y;
	logic signed [ROT_WIDTH-1:0] rot_deg;
	logic [COLOUR_WIDTH-1:0]     colour;
	ext_t  sw_abs, pu0, pu1, pv0, pv1;
	side_t side_in;

	logic en;
	logic valid_s [1:12];
	side_t side_s [1:9];

	cs_t cos_s9, sin_s9;
	uv_t u0_s9, u1_s9, v0_s9, v1_s9;

	// stage 10: products
	logic signed [PROD_WIDTH-1:0] pac_s10 [0:1];
	logic signed [PROD_WIDTH-1:0] pas_s10 [0:1];
	logic signed [PROD_WIDTH-1:0] pbs_s10 [0:1];
	logic signed [PROD_WIDTH-1:0] pbc_s10 [0:1];
	pos_t dst_x_s10, dst_y_s10, dst_x_s11, dst_y_s11;
	logic [COLOUR_WIDTH-1:0] colour_s10, colour_s11, colour_s12;
	uv_t ua_s10, ub_s10, v0_s10, v1_s10;
	uv_t ua_s11, ub_s11, v0_s11, v1_s11;
	uv_t ua_s12, ub_s12, v0_s12, v1_s12;

	// stage 11: rounded rotated offsets per corner, stage 12: corner positions
	logic signed [RND_WIDTH-1:0] rx_s11 [0:3];
	logic signed [RND_WIDTH-1:0] ry_s11 [0:3];
	pos_t px_s12 [0:3];
	pos_t py_s12 [0:3];

	logic [2:0] cnt_q;
	logic [1:0] corner;
	logic       take;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q  <= '0;
			tex_height_q <= '0;
			depth_z_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TEX_WIDTH:  tex_width_q  <= cfg_wdata[TEX_WIDTH-1:0];
				REG_TEX_HEIGHT: tex_height_q <= cfg_wdata[TEX_WIDTH-1:0];
				REG_DEPTH_Z:    depth_z_q    <= cfg_wdata[DEPTH_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// field unpacking, lowest field first
	always_comb begin
		dst_x    = s_tdata[23:0];
		dst_y    = s_tdata[47:24];
		dst_w    = s_tdata[71:48];
		dst_h    = s_tdata[95:72];
		src_x    = s_tdata[119:96];
		src_y    = s_tdata[143:120];
		src_w    = s_tdata[167:144];
		src_h    = s_tdata[191:168];
		rot_deg  = s_tdata[208:192];
		origin_x = s_tdata[232:209];
		origin_y = s_tdata[256:233];
		colour   = s_tdata[288:257];
	end

	// corner offsets relative to the destination point, and texture extents
	always_comb begin
		sw_abs = (src_w < 0) ? -P_WIDTH'(src_w) : P_WIDTH'(src_w);
		pu0    = P_WIDTH'(src_x);
		pu1    = P_WIDTH'(src_x) + sw_abs;
		if (src_h < 0) begin
			pv0 = P_WIDTH'(src_y) - P_WIDTH'(src_h);
			pv1 = P_WIDTH'(src_y);
		end else begin
			pv0 = P_WIDTH'(src_y);
			pv1 = P_WIDTH'(src_y) + P_WIDTH'(src_h);
		end
		side_in.dst_x  = dst_x;
		side_in.dst_y  = dst_y;
		side_in.ax0    = -P_WIDTH'(origin_x);
		side_in.ax1    = P_WIDTH'(dst_w) - P_WIDTH'(origin_x);
		side_in.by0    = -P_WIDTH'(origin_y);
		side_in.by1    = P_WIDTH'(dst_h) - P_WIDTH'(origin_y);
		side_in.colour = colour;
		side_in.flip   = src_w < 0;
	end

	// the whole pipe moves when the output stage is free or drains its last vertex
	assign take     = m_tvalid && m_tready && (cnt_q == LAST_VTX);
	assign en       = !valid_s[12] || take;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 12; k++)
				valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[1] <= s_tvalid;
			for (int k = 2; k <= 12; k++)
				valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1] <= side_in;
			for (int k = 2; k <= 9; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	// stages 1 to 9: sine and cosine, and the four texture coordinates
	svqe_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.rot     (rot_deg),
		.cos_val (cos_s9),
		.sin_val (sin_s9)
	);

	svqe_uv_div u_div_u0 (.clk(clk), .en(en), .p(pu0), .size(tex_width_q),  .uv(u0_s9));
	svqe_uv_div u_div_u1 (.clk(clk), .en(en), .p(pu1), .size(tex_width_q),  .uv(u1_s9));
	svqe_uv_div u_div_v0 (.clk(clk), .en(en), .p(pv0), .size(tex_height_q), .uv(v0_s9));
	svqe_uv_div u_div_v1 (.clk(clk), .en(en), .p(pv1), .size(tex_height_q), .uv(v1_s9));

	// stage 10: eight products, mirrored u swaps the pair
	always_ff @(posedge clk) begin
		if (en) begin
			pac_s10[0] <= side_s[9].ax0 * cos_s9;
			pac_s10[1] <= side_s[9].ax1 * cos_s9;
			pas_s10[0] <= side_s[9].ax0 * sin_s9;
			pas_s10[1] <= side_s[9].ax1 * sin_s9;
			pbs_s10[0] <= side_s[9].by0 * sin_s9;
			pbs_s10[1] <= side_s[9].by1 * sin_s9;
			pbc_s10[0] <= side_s[9].by0 * cos_s9;
			pbc_s10[1] <= side_s[9].by1 * cos_s9;
			dst_x_s10  <= side_s[9].dst_x;
			dst_y_s10  <= side_s[9].dst_y;
			colour_s10 <= side_s[9].colour;
			ua_s10     <= side_s[9].flip ? u1_s9 : u0_s9;
			ub_s10     <= side_s[9].flip ? u0_s9 : u1_s9;
			v0_s10     <= v0_s9;
			v1_s10     <= v1_s9;
		end
	end

	// stage 11: corner order TL, TR, BR, BL; round half up from Q.16
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				rx_s11[k] <= RND_WIDTH'(((PROD_WIDTH+1)'(pac_s10[(k == 1 || k == 2) ? 1 : 0])
				           - (PROD_WIDTH+1)'(pbs_s10[(k >= 2) ? 1 : 0])
				           + (PROD_WIDTH+1)'(32768)) >>> 16);
				ry_s11[k] <= RND_WIDTH'(((PROD_WIDTH+1)'(pas_s10[(k == 1 || k == 2) ? 1 : 0])
				           + (PROD_WIDTH+1)'(pbc_s10[(k >= 2) ? 1 : 0])
				           + (PROD_WIDTH+1)'(32768)) >>> 16);
			end
			dst_x_s11  <= dst_x_s10;
			dst_y_s11  <= dst_y_s10;
			colour_s11 <= colour_s10;
			ua_s11     <= ua_s10;
			ub_s11     <= ub_s10;
			v0_s11     <= v0_s10;
			v1_s11     <= v1_s10;
		end
	end

	// stage 12: output register holding one whole quad
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				px_s12[k] <= sat_pos((RND_WIDTH+1)'(dst_x_s11) + (RND_WIDTH+1)'(rx_s11[k]));
				py_s12[k] <= sat_pos((RND_WIDTH+1)'(dst_y_s11) + (RND_WIDTH+1)'(ry_s11[k]));
			end
			colour_s12 <= colour_s11;
			ua_s12     <= ua_s11;
			ub_s12     <= ub_s11;
			v0_s12     <= v0_s11;
			v1_s12     <= v1_s11;
		end
	end

	// vertex counter over the six vertices of the held quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (m_tvalid && m_tready)
			cnt_q <= (cnt_q == LAST_VTX) ? 3'd0 : cnt_q + 3'd1;
	end

	// triangles TL,TR,BR then BR,BL,TL
	always_comb begin
		case (cnt_q)
			3'd0:    corner = 2'd0;
			3'd1:    corner = 2'd1;
			3'd2:    corner = 2'd2;
			3'd3:    corner = 2'd2;
			3'd4:    corner = 2'd3;
			default: corner = 2'd0;
		endcase
	end

	assign m_tvalid = valid_s[12];
	assign m_tlast  = cnt_q == LAST_VTX;
	assign m_tdata  = {depth_z_q,
	                   colour_s12,
	                   (corner[1]) ? v1_s12 : v0_s12,
	                   (corner == 2'd1 || corner == 2'd2) ? ub_s12 : ua_s12,
	                   py_s12[corner],
	                   px_s12[corner]};

	`include "sprite_quad_vertex_expander_assert.svh"

	// a quad stays on the output until its last vertex goes
	`SVQE_ASSERT_NEXT(a_quad_held, m_tvalid && !(m_tready && m_tlast), m_tvalid)
	// no new request while the held quad still drains
	`SVQE_ASSERT_NOW(a_no_take_busy, m_tvalid && !(m_tready && m_tlast), !s_tready)
	// counter never leaves the six vertex range
	`SVQE_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= LAST_VTX)
	// output empties after the last vertex when nothing follows
	`SVQE_ASSERT_NEXT(a_drain, m_tvalid && m_tready && m_tlast && !valid_s[11], !m_tvalid)

endmodule
`default_nettype wire
